>>> hw/rtl/prq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types, codes and sizes of the priority ready-queue scheduler.
// ----------------------------------------------------------------------------
package prq_pkg;

  // Queue geometry and field widths
  localparam int MAX_TASKS = 32;
  localparam int ID_W      = 5;
  localparam int PRIO_W    = 8;
  localparam int POS_W     = $clog2(MAX_TASKS);
  localparam int LEN_W     = $clog2(MAX_TASKS + 1);
  localparam int STATUS_W  = 3;
  localparam int CMD_W     = 2;
  localparam int CSTATE_W  = 2;

  // Stream and configuration port widths
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = ID_W;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SCHED  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOSWITCH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SWITCHED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

  // Current task state codes
  localparam logic [CSTATE_W-1:0] CS_RUNNING    = 2'd0;
  localparam logic [CSTATE_W-1:0] CS_TERMINATED = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE   = 1'd1;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REQ
  } prq_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic step1;
    logic step2;
  } prq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_step2;
    logic out_busy;
  } prq_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/prq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prq_ctrl
// Sequencer: takes one command, runs its first step, and a second insert
// step for a schedule that popped the queue head.
// ----------------------------------------------------------------------------
module prq_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               s_tvalid,
  output logic              s_tready,
  input  prq_pkg::prq_stat_t stat,
  output prq_pkg::prq_cmd_t  cmd
);
  import prq_pkg::*;

  prq_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the result slot is free
        if (!stat.out_busy) begin
          cmd.step1  = 1'b1;
          state_next = stat.need_step2 ? S_REQ : S_IDLE;
        end
      end
      S_REQ: begin
        cmd.step2  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Checks
  a_steps_apart: assert property (@(posedge clk) disable iff (rst)
    !(cmd.step1 && cmd.step2))
    else $error("both steps issued in one cycle");

  a_req_returns: assert property (@(posedge clk) disable iff (rst)
    (state == S_REQ) |=> (state == S_IDLE))
    else $error("second step did not return to idle");

  a_step1_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.step1 |-> !stat.out_busy)
    else $error("first step issued while result slot busy");

endmodule
`default_nettype wire

>>> hw/rtl/prq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prq_datapath
// Sorted ready queue in registers with one shared insert/shift unit and
// one delete/shift unit, the command register, config and result register.
// ----------------------------------------------------------------------------
module prq_datapath (
  input  wire                                clk,
  input  wire                                rst,
  input  prq_pkg::prq_cmd_t                  cmd,
  output prq_pkg::prq_stat_t                 stat,
  input  wire  [prq_pkg::S_TDATA_W-1:0]      s_tdata,
  input  wire  [prq_pkg::CMD_W-1:0]          s_tuser,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [prq_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic [prq_pkg::STATUS_W-1:0]       m_tuser,
  input  wire                                cfg_we,
  input  wire  [prq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [prq_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import prq_pkg::*;

  // Queue storage
  logic [ID_W-1:0]   q_ids   [MAX_TASKS];
  logic [PRIO_W-1:0] q_prios [MAX_TASKS];
  logic [LEN_W-1:0]  q_len;

  // Config registers
  logic            cfg_enable;
  logic [ID_W-1:0] cfg_idle;

  // Command register
  logic [CMD_W-1:0]    in_cmd;
  logic [ID_W-1:0]     in_id;
  logic [PRIO_W-1:0]   in_prio;
  logic                in_running;
  logic                in_cur_valid;
  logic [ID_W-1:0]     in_cur_id;
  logic [PRIO_W-1:0]   in_cur_prio;
  logic                in_cur_kernel;
  logic [CSTATE_W-1:0] in_cur_state;
  logic                in_irq;
  logic                in_irq_user;
  logic                in_preempt_ok;

  // Pending reinsert for the second step
  logic              s2_do, s2_do_next;
  logic [ID_W-1:0]   s2_id, s2_id_next;
  logic [PRIO_W-1:0] s2_prio, s2_prio_next;

  // Result register
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_next_id;
  logic [LEN_W-1:0]    out_count;

  // Shared unit controls
  logic              ins_en, del_en;
  logic [ID_W-1:0]   sel_id;
  logic [PRIO_W-1:0] sel_prio;
  logic [POS_W-1:0]  del_pos;
  logic [LEN_W-1:0]  len_next;
  logic [STATUS_W-1:0] res_status;
  logic [ID_W-1:0]     res_next_id;

  // Search results
  logic [MAX_TASKS-1:0] valid, match, le, le_prev;
  logic                 found;
  logic [POS_W-1:0]     found_pos;

  // Schedule decode
  logic terminated, no_switch, keep_head;

  logic [ID_W-1:0]   qn_ids   [MAX_TASKS];
  logic [PRIO_W-1:0] qn_prios [MAX_TASKS];
  logic [ID_W-1:0]   up_ids   [MAX_TASKS];
  logic [PRIO_W-1:0] up_prios [MAX_TASKS];
  logic [ID_W-1:0]   dn_ids   [MAX_TASKS];
  logic [PRIO_W-1:0] dn_prios [MAX_TASKS];

  // Capture the command on transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_cmd        <= s_tuser;
      in_id         <= s_tdata[4:0];
      in_prio       <= s_tdata[12:5];
      in_running    <= s_tdata[13];
      in_cur_valid  <= s_tdata[14];
      in_cur_id     <= s_tdata[19:15];
      in_cur_prio   <= s_tdata[27:20];
      in_cur_kernel <= s_tdata[28];
      in_cur_state  <= s_tdata[30:29];
      in_irq        <= s_tdata[31];
      in_irq_user   <= s_tdata[32];
      in_preempt_ok <= s_tdata[33];
    end
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_enable <= 1'b0;
      cfg_idle   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE: cfg_enable <= cfg_data[0];
        CFG_IDLE:   cfg_idle   <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Select the key for search and insert
  assign sel_id   = cmd.step2 ? s2_id   : in_id;
  assign sel_prio = cmd.step2 ? s2_prio : in_prio;

  // Compare every entry in parallel
  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      valid[i] = (LEN_W'(i) < q_len);
      match[i] = valid[i] && (q_ids[i] == sel_id);
      le[i]    = valid[i] && (q_prios[i] <= sel_prio);
    end
    le_prev[0] = 1'b1;
    for (int i = 1; i < MAX_TASKS; i++) begin
      le_prev[i] = le[i-1];
    end
  end

  // Find the first matching entry
  always_comb begin
    found_pos = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_pos = POS_W'(i);
      end
    end
  end
  assign found = |match;

  // Schedule gating
  assign terminated = (in_cur_state == CS_TERMINATED);
  assign no_switch  = !cfg_enable || (q_len == '0) || !in_cur_valid ||
                      (in_irq && !in_irq_user && (in_cur_id != '0) &&
                       !terminated && !in_preempt_ok);
  assign keep_head  = (q_ids[0] == in_cur_id) ||
                      (!in_cur_kernel && !terminated && (q_ids[0] == cfg_idle));

  // Status to the controller
  always_comb begin
    stat.need_step2 = (in_cmd == CMD_SCHED) && !no_switch;
    stat.out_busy   = m_tvalid && !m_tready;
  end

  // Decide the operation of each step
  always_comb begin
    ins_en       = 1'b0;
    del_en       = 1'b0;
    del_pos      = found_pos;
    res_status   = ST_REFUSED;
    res_next_id  = '0;
    s2_do_next   = s2_do;
    s2_id_next   = s2_id;
    s2_prio_next = s2_prio;
    if (cmd.step1) begin
      case (in_cmd)
        CMD_ADD: begin
          if (in_running || found) begin
            res_status = ST_REFUSED;
          end else if (q_len == LEN_W'(MAX_TASKS)) begin
            res_status = ST_FULL;
          end else begin
            ins_en     = 1'b1;
            res_status = ST_DONE;
          end
        end
        CMD_REMOVE: begin
          if (found) begin
            del_en     = 1'b1;
            res_status = ST_DONE;
          end else begin
            res_status = ST_NOTFOUND;
          end
        end
        CMD_SCHED: begin
          if (no_switch) begin
            res_status = ST_NOSWITCH;
          end else begin
            // pop the head, queue the reinsert for the next step
            del_en  = 1'b1;
            del_pos = '0;
            if (keep_head) begin
              res_status   = ST_NOSWITCH;
              s2_do_next   = 1'b1;
              s2_id_next   = q_ids[0];
              s2_prio_next = q_prios[0];
            end else begin
              res_status   = ST_SWITCHED;
              res_next_id  = q_ids[0];
              s2_do_next   = (in_cur_state == CS_RUNNING);
              s2_id_next   = in_cur_id;
              s2_prio_next = in_cur_prio;
            end
          end
        end
        default: begin
          res_status = ST_REFUSED;
        end
      endcase
    end else if (cmd.step2) begin
      // skip the requeue when the id is already queued
      ins_en     = s2_do && !found && (q_len != LEN_W'(MAX_TASKS));
      s2_do_next = 1'b0;
    end
  end

  // Neighbor views for shifting
  always_comb begin
    up_ids[0]   = sel_id;
    up_prios[0] = sel_prio;
    for (int i = 1; i < MAX_TASKS; i++) begin
      up_ids[i]   = q_ids[i-1];
      up_prios[i] = q_prios[i-1];
    end
    for (int i = 0; i < MAX_TASKS - 1; i++) begin
      dn_ids[i]   = q_ids[i+1];
      dn_prios[i] = q_prios[i+1];
    end
    dn_ids[MAX_TASKS-1]   = q_ids[MAX_TASKS-1];
    dn_prios[MAX_TASKS-1] = q_prios[MAX_TASKS-1];
  end

  // Insert after equal or lower values, or close the gap of a delete
  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      qn_ids[i]   = q_ids[i];
      qn_prios[i] = q_prios[i];
      if (ins_en && !le[i]) begin
        if (le_prev[i]) begin
          qn_ids[i]   = sel_id;
          qn_prios[i] = sel_prio;
        end else begin
          qn_ids[i]   = up_ids[i];
          qn_prios[i] = up_prios[i];
        end
      end else if (del_en && (POS_W'(i) >= del_pos)) begin
        qn_ids[i]   = dn_ids[i];
        qn_prios[i] = dn_prios[i];
      end
    end
  end

  always_comb begin
    len_next = q_len;
    if (ins_en) begin
      len_next = q_len + LEN_W'(1);
    end else if (del_en) begin
      len_next = q_len - LEN_W'(1);
    end
  end

  // Queue entries
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      q_ids[i]   <= qn_ids[i];
      q_prios[i] <= qn_prios[i];
    end
    s2_id   <= s2_id_next;
    s2_prio <= s2_prio_next;
  end

  // Queue length and pending reinsert flag
  always_ff @(posedge clk) begin
    if (rst) begin
      q_len <= '0;
      s2_do <= 1'b0;
    end else begin
      q_len <= len_next;
      s2_do <= s2_do_next;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.step1) begin
      out_status  <= res_status;
      out_next_id <= res_next_id;
    end
    if (cmd.step1 || cmd.step2) begin
      out_count <= len_next;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.step2 || (cmd.step1 && !stat.need_step2)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {{(M_TDATA_W - ID_W - LEN_W){1'b0}}, out_count, out_next_id};

  // Checks
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    q_len <= LEN_W'(MAX_TASKS))
    else $error("queue length beyond capacity");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    ins_en |=> (q_len == $past(q_len) + LEN_W'(1)))
    else $error("insert did not grow the queue");

  a_step2_delivers: assert property (@(posedge clk) disable iff (rst)
    cmd.step2 |=> m_tvalid)
    else $error("second step left no result");

  a_ops_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ins_en && del_en))
    else $error("insert and delete in one cycle");

endmodule
`default_nettype wire

>>> hw/rtl/priority_ready_queue_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A result is registered by the first step for add, remove and a schedule
//   gated off before the pop, and by the second step for a schedule that
//   pops the head. A result still held at the output delays the next one.
// A new command is taken only once the previous one is through: the capture
//   plus one step, or two steps when the head is popped.
// Reset (synchronous): queue empty, enable 0, idle id 0, no result pending.
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_core
// Ready queue of task ids sorted by priority with add, remove and schedule.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler_core (
  input  wire                           clk,
  input  wire                           rst,
  // task_id, priority_req, already_running, cur_valid, cur_task_id, cur_priority,
  // cur_is_kernel, cur_state, from_irq, irq_from_user, cur_preempt_ok
  input  wire  [prq_pkg::S_TDATA_W-1:0] s_tdata,
  // cmd
  input  wire  [prq_pkg::CMD_W-1:0]     s_tuser,
  input  wire                           s_tvalid,
  output logic                          s_tready,
  // next_task_id, queue_count
  output logic [prq_pkg::M_TDATA_W-1:0] m_tdata,
  // status
  output logic [prq_pkg::STATUS_W-1:0]  m_tuser,
  output logic                          m_tvalid,
  input  wire                           m_tready,
  input  wire                           cfg_we,
  input  wire  [prq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [prq_pkg::CFG_DAT_W-1:0] cfg_data
);
  import prq_pkg::*;

  prq_cmd_t  cmd;
  prq_stat_t stat;

  // Sequencer
  prq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Queue and result datapath
  prq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the priority ready-queue scheduler core. Requests
// are queued by a stimulus process and sent by a clocked driver. The driver
// updates a local copy of the ready queue on every transfer and records the
// expected response. A clocked monitor compares each response, field by
// field, against the oldest recorded one. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb;
  import prq_pkg::*;

  // Codes the package does not name
  localparam logic [CMD_W-1:0]    CMD_UNUSED = 2'd3;
  localparam logic [CSTATE_W-1:0] CS_OTHER   = 2'd1;
  localparam logic [CSTATE_W-1:0] CS_SPARE   = 2'd3;

  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 3000;

  // One scheduler request, fields as the block sees them
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [ID_W-1:0]     task_id;
    logic [PRIO_W-1:0]   prio;
    logic                already_running;
    logic                cur_valid;
    logic [ID_W-1:0]     cur_id;
    logic [PRIO_W-1:0]   cur_prio;
    logic                cur_is_kernel;
    logic [CSTATE_W-1:0] cur_state;
    logic                from_irq;
    logic                irq_from_user;
    logic                cur_preempt_ok;
  } ready_req_t;

  // One scheduler response
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     next_id;
    logic [LEN_W-1:0]    count;
  } ready_rsp_t;

  // Ready queue entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } ready_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic [CMD_W-1:0]     s_tuser   = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]  m_tuser;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  // Local copy of the scheduler state
  ready_entry_t     ready_q[$];
  logic             cfg_enable = 1'b0;
  logic [ID_W-1:0]  cfg_idle   = '0;

  ready_req_t req_pending[$];
  ready_req_t req_cur;
  ready_rsp_t rsp_expected[$];
  ready_rsp_t rsp_want;

  int  n_issued   = 0;
  int  n_accepted = 0;
  int  n_errors   = 0;
  int  gap_pct    = 0;
  int  stall_pct  = 0;
  int  src_gap    = 0;
  int  sink_gap   = 0;
  int  hold_cnt   = 0;
  int  quiet_cycles = 0;
  bit  hold_req   = 1'b0;
  bit  src_busy;
  bit  sink_rdy;

  priority_ready_queue_scheduler_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Ready queue prediction
  // --------------------------------------------------------------------------
  function automatic int find_task(input logic [ID_W-1:0] id);
    for (int i = 0; i < ready_q.size(); i++) begin
      if (ready_q[i].id == id) return i;
    end
    return -1;
  endfunction

  // Insert behind every entry of equal or lower value
  function automatic logic [STATUS_W-1:0] enqueue_task(input logic [ID_W-1:0] id,
                                                       input logic [PRIO_W-1:0] prio);
    int           pos;
    ready_entry_t e;
    if (find_task(id) >= 0) return ST_REFUSED;
    if (ready_q.size() >= MAX_TASKS) return ST_FULL;
    pos = 0;
    while (pos < ready_q.size() && ready_q[pos].prio <= prio) pos++;
    e.id   = id;
    e.prio = prio;
    ready_q.insert(pos, e);
    return ST_DONE;
  endfunction

  function automatic logic [STATUS_W-1:0] schedule_task(input ready_req_t r,
                                                        output logic [ID_W-1:0] nxt);
    ready_entry_t head;
    logic         ended;
    nxt   = '0;
    ended = (r.cur_state == CS_TERMINATED);
    if (!cfg_enable || ready_q.size() == 0 || !r.cur_valid) return ST_NOSWITCH;
    // interrupt-time gate on a non-preemptible kernel context
    if (r.from_irq && !r.irq_from_user && r.cur_id != '0 && !ended && !r.cur_preempt_ok)
      return ST_NOSWITCH;
    head = ready_q.pop_front();
    if (head.id == r.cur_id || (!r.cur_is_kernel && !ended && head.id == cfg_idle)) begin
      void'(enqueue_task(head.id, head.prio));
      return ST_NOSWITCH;
    end
    if (r.cur_state == CS_RUNNING) void'(enqueue_task(r.cur_id, r.cur_prio));
    nxt = head.id;
    return ST_SWITCHED;
  endfunction

  function automatic ready_rsp_t predict_ready_queue(input ready_req_t r);
    ready_rsp_t      rsp;
    int              pos;
    logic [ID_W-1:0] nxt;
    rsp = '0;
    case (r.cmd)
      CMD_ADD: begin
        rsp.status = r.already_running ? ST_REFUSED : enqueue_task(r.task_id, r.prio);
      end
      CMD_REMOVE: begin
        pos = find_task(r.task_id);
        if (pos >= 0) begin
          ready_q.delete(pos);
          rsp.status = ST_DONE;
        end else begin
          rsp.status = ST_NOTFOUND;
        end
      end
      CMD_SCHED: begin
        rsp.status  = schedule_task(r, nxt);
        rsp.next_id = nxt;
      end
      default: begin
        rsp.status = ST_REFUSED;
      end
    endcase
    rsp.count = LEN_W'(ready_q.size());
    return rsp;
  endfunction

  function automatic logic [S_TDATA_W-1:0] pack_req(input ready_req_t r);
    return {6'b0, r.cur_preempt_ok, r.irq_from_user, r.from_irq, r.cur_state,
            r.cur_is_kernel, r.cur_prio, r.cur_id, r.cur_valid, r.already_running,
            r.prio, r.task_id};
  endfunction

  // --------------------------------------------------------------------------
  // Request builders
  // --------------------------------------------------------------------------
  function automatic ready_req_t make_req(input logic [CMD_W-1:0] cmd,
                                          input logic [ID_W-1:0] id,
                                          input logic [PRIO_W-1:0] prio);
    ready_req_t r;
    r               = '0;
    r.cmd           = cmd;
    r.task_id       = id;
    r.prio          = prio;
    r.cur_valid     = 1'b1;
    r.cur_is_kernel = 1'b1;
    r.cur_state     = CS_RUNNING;
    return r;
  endfunction

  function automatic ready_req_t make_sched(input logic [ID_W-1:0] cur_id,
                                            input logic [PRIO_W-1:0] cur_prio,
                                            input logic kernel,
                                            input logic [CSTATE_W-1:0] cstate,
                                            input logic irq, input logic user,
                                            input logic preempt_ok);
    ready_req_t r;
    r                = make_req(CMD_SCHED, '0, '0);
    r.cur_id         = cur_id;
    r.cur_prio       = cur_prio;
    r.cur_is_kernel  = kernel;
    r.cur_state      = cstate;
    r.from_irq       = irq;
    r.irq_from_user  = user;
    r.cur_preempt_ok = preempt_ok;
    return r;
  endfunction

  // Mostly small values so that ties are common
  function automatic logic [PRIO_W-1:0] rand_prio();
    case ($urandom_range(0, 3))
      0, 1:    return PRIO_W'($urandom_range(0, 7));
      2:       return PRIO_W'($urandom());
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  function automatic logic [ID_W-1:0] rand_id(input int id_hi);
    if ($urandom_range(0, 5) == 0) return cfg_idle;
    return ID_W'($urandom_range(0, id_hi));
  endfunction

  function automatic ready_req_t rand_req(input int add_pct, input int id_hi);
    ready_req_t r;
    int         pick;
    pick              = $urandom_range(0, 99);
    r.cmd             = (pick < add_pct) ? CMD_ADD :
                        (pick < add_pct + (100 - add_pct) / 3) ? CMD_REMOVE :
                        (pick < 97) ? CMD_SCHED : CMD_UNUSED;
    r.task_id         = rand_id(id_hi);
    r.prio            = rand_prio();
    r.already_running = ($urandom_range(0, 7) == 0);
    r.cur_valid       = ($urandom_range(0, 7) != 0);
    r.cur_id          = ($urandom_range(0, 7) == 0) ? '0 : rand_id(id_hi);
    r.cur_prio        = rand_prio();
    r.cur_is_kernel   = 1'($urandom_range(0, 1));
    pick              = $urandom_range(0, 9);
    r.cur_state       = (pick < 5) ? CS_RUNNING : (pick < 7) ? CS_OTHER :
                        (pick < 9) ? CS_TERMINATED : CS_SPARE;
    r.from_irq        = 1'($urandom_range(0, 1));
    r.irq_from_user   = 1'($urandom_range(0, 1));
    r.cur_preempt_ok  = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic issue(input ready_req_t r);
    req_pending.push_back(r);
    n_issued++;
  endtask

  task automatic issue_random(input int n, input int add_pct, input int id_hi);
    for (int i = 0; i < n; i++) issue(rand_req(add_pct, id_hi));
  endtask

  // Wait until every request is through and every response has come back
  task automatic wait_drained();
    @(negedge clk);
    while (n_accepted != n_issued || rsp_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_ENABLE) cfg_enable = val[0];
    else cfg_idle = val;
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct);
    @(negedge clk);
    gap_pct   = src_pct;
    stall_pct = sink_pct;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: send pending requests, predict on each transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      src_busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        rsp_expected.push_back(predict_ready_queue(req_cur));
        n_accepted++;
        src_busy = 1'b0;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) src_gap = $urandom_range(1, 9);
      end
      if (!src_busy) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (req_pending.size() > 0) begin
          req_cur = req_pending.pop_front();
          s_tdata <= pack_req(req_cur);
          s_tuser <= req_cur.cmd;
          src_busy = 1'b1;
        end
      end
      s_tvalid <= src_busy;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each response, drive backpressure
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap = 0;
      hold_cnt = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (rsp_expected.size() == 0) begin
          $display("%0t: unexpected response, expected none actual status %0d",
                   $time, m_tuser);
          n_errors++;
        end else begin
          rsp_want = rsp_expected.pop_front();
          check_field("status", rsp_want.status, m_tuser);
          check_field("next_task_id", rsp_want.next_id, m_tdata[ID_W-1:0]);
          check_field("queue_count", rsp_want.count, m_tdata[ID_W +: LEN_W]);
        end
      end
      // long hold-off on request, otherwise short random stalls
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        sink_rdy = 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        sink_rdy = 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        sink_gap = $urandom_range(1, 9) - 1;
        sink_rdy = 1'b0;
      end else begin
        sink_rdy = 1'b1;
      end
      m_tready <= sink_rdy;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no transfer happens for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    ready_req_t r;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_idling(20, 20);

    // Queue basics while scheduling is still disabled
    issue(make_sched(5'd3, 8'd7, 1'b1, CS_RUNNING, 1'b0, 1'b0, 1'b0));
    issue(make_req(CMD_ADD, 5'd0, 8'd255));
    issue(make_req(CMD_ADD, 5'd31, 8'd0));
    issue(make_req(CMD_ADD, 5'd5, 8'd0));
    issue(make_req(CMD_ADD, 5'd31, 8'd9));
    r = make_req(CMD_ADD, 5'd12, 8'd4);
    r.already_running = 1'b1;
    issue(r);
    issue(make_req(CMD_REMOVE, 5'd7, 8'd0));
    issue(make_req(CMD_UNUSED, 5'd31, 8'd255));
    issue(make_sched(5'd3, 8'd7, 1'b1, CS_RUNNING, 1'b0, 1'b0, 1'b0));
    issue(make_req(CMD_REMOVE, 5'd5, 8'd0));
    issue(make_req(CMD_ADD, 5'd17, 8'd255));
    wait_drained();

    // Schedule corner cases with the idle task at the top id
    write_reg(CFG_ENABLE, CFG_DAT_W'(1));
    write_reg(CFG_IDLE, CFG_DAT_W'(31));
    r = make_sched(5'd3, 8'd7, 1'b1, CS_RUNNING, 1'b0, 1'b0, 1'b0);
    r.cur_valid = 1'b0;
    issue(r);
    // interrupt gate, head is the current task, head is the idle task
    issue(make_sched(5'd3, 8'd7, 1'b1, CS_RUNNING, 1'b1, 1'b0, 1'b0));
    issue(make_sched(5'd31, 8'd7, 1'b1, CS_RUNNING, 1'b0, 1'b0, 1'b0));
    issue(make_sched(5'd3, 8'd7, 1'b0, CS_OTHER, 1'b0, 1'b0, 1'b0));
    // switch with requeue, then a terminated task passing the gate
    issue(make_sched(5'd3, 8'd7, 1'b1, CS_RUNNING, 1'b1, 1'b1, 1'b0));
    issue(make_sched(5'd9, 8'd0, 1'b0, CS_TERMINATED, 1'b1, 1'b0, 1'b0));
    // requeue skipped for an id that is already queued
    issue(make_req(CMD_ADD, 5'd9, 8'd200));
    issue(make_req(CMD_ADD, 5'd4, 8'd0));
    issue(make_sched(5'd9, 8'd1, 1'b1, CS_RUNNING, 1'b0, 1'b0, 1'b0));
    // task id zero bypasses the gate; unused state code acts as blocked
    issue(make_sched(5'd0, 8'd255, 1'b1, CS_RUNNING, 1'b1, 1'b0, 1'b0));
    issue(make_sched(5'd20, 8'd255, 1'b1, CS_SPARE, 1'b1, 1'b0, 1'b1));
    issue(make_req(CMD_REMOVE, 5'd17, 8'd0));
    issue(make_sched(5'd3, 8'd7, 1'b1, CS_RUNNING, 1'b0, 1'b0, 1'b0));
    wait_drained();

    // Random traffic over the full id range
    write_reg(CFG_IDLE, CFG_DAT_W'(3));
    issue_random(250, 50, 31);
    wait_drained();

    // Receiver holds off while requests keep coming
    write_reg(CFG_IDLE, CFG_DAT_W'(0));
    set_idling(10, 0);
    hold_req = 1'b1;
    issue_random(150, 60, 31);
    wait_drained();

    // Scheduling disabled, crowded id space
    write_reg(CFG_ENABLE, CFG_DAT_W'(0));
    set_idling(30, 30);
    issue_random(100, 40, 7);
    wait_drained();

    // Few ids so that heads, duplicates and idle hits are common; no idling
    write_reg(CFG_ENABLE, CFG_DAT_W'(1));
    write_reg(CFG_IDLE, CFG_DAT_W'(31));
    set_idling(0, 0);
    issue_random(250, 40, 7);
    wait_drained();

    write_reg(CFG_IDLE, CFG_DAT_W'(5));
    set_idling(25, 25);
    issue_random(200, 55, 31);
    wait_drained();

    // Final stretch at full rate
    set_idling(0, 0);
    issue_random(200, 45, 15);
    wait_drained();

    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
